// ----- rtl/sms_pkg.sv -----
// Shared types, codes and helpers of the sparse matrix store with SpMV.
`timescale 1ns / 1ps
package sms_pkg;

    localparam int VALUE_BITS = 32;
    localparam int MAX_ROWS   = 64;
    localparam int MAX_COLS   = 64;
    localparam int VEC_DEPTH  = MAX_COLS;
    localparam int VEC_AW     = $clog2(VEC_DEPTH);

    localparam logic [2:0] CMD_INSERT = 3'd0;
    localparam logic [2:0] CMD_VEC_WR = 3'd1;
    localparam logic [2:0] CMD_LOOKUP = 3'd2;
    localparam logic [2:0] CMD_MUL    = 3'd3;
    localparam logic [2:0] CMD_CLEAR  = 3'd4;

    localparam logic [1:0] ST_OK    = 2'd0;
    localparam logic [1:0] ST_RANGE = 2'd1;
    localparam logic [1:0] ST_FULL  = 2'd2;

    localparam logic [1:0] CFG_ROWS = 2'd0;
    localparam logic [1:0] CFG_COLS = 2'd1;
    localparam logic [1:0] CFG_TOL  = 2'd2;

    typedef struct packed {
        logic [2:0]         command;
        logic [5:0]         row_index;
        logic [5:0]         col_index;
        logic signed [31:0] value_in;
    } t_cmd_in;

    typedef struct packed {
        logic [1:0]         status;
        logic signed [31:0] value_out;
        logic [5:0]         result_row;
        logic [8:0]         entry_count;
        logic               last;
    } t_result;

    typedef struct packed {
        logic [5:0]         row;
        logic [5:0]         col;
        logic signed [31:0] val;
    } t_entry;

    typedef enum logic [2:0] {
        J_REPLY, J_INSERT, J_VEC, J_LOOKUP, J_MUL, J_CLEAR
    } t_job_kind;

    typedef struct packed {
        t_job_kind          kind;
        logic [1:0]         status;
        logic [5:0]         row;
        logic [5:0]         col;
        logic signed [31:0] value;
    } t_job;

    typedef struct packed {
        logic [6:0]  rows;
        logic [6:0]  cols;
        logic [30:0] tol;
    } t_limits;

    typedef enum logic [2:0] {
        S_IDLE, S_SCAN, S_DEL_RD, S_DEL_WR, S_EMIT, S_MSCAN, S_MEMIT
    } t_state;

    // Magnitude at or below the tolerance counts as zero.
    function automatic logic f_small(input logic signed [32:0] v, input logic [30:0] t);
        logic signed [32:0] st;
        st = $signed({2'b00, t});
        return (v <= st) && (v >= -st);
    endfunction

endpackage

// ----- rtl/sms_ram.sv -----
// Generic single-write, single-read RAM with registered read data.
`timescale 1ns / 1ps
module sms_ram #(
    parameter int WIDTH = 44,
    parameter int DEPTH = 256,
    parameter int AW    = $clog2(DEPTH)
) (
    input  logic             i_clk,
    input  logic             i_we,
    input  logic [AW-1:0]    i_waddr,
    input  logic [WIDTH-1:0] i_wdata,
    input  logic [AW-1:0]    i_raddr,
    output logic [WIDTH-1:0] o_rdata
);
    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        r_rdata <= r_mem[i_raddr];
    end

    assign o_rdata = r_rdata;
endmodule

// ----- rtl/sms_front.sv -----
// Front end: configuration registers and command classification.
`timescale 1ns / 1ps
module sms_front (
    input  logic                i_clk,
    input  logic                i_rst_n,
    input  logic                i_cfg_we,
    input  logic [1:0]          i_cfg_idx,
    input  logic [30:0]         i_cfg_data,
    input  sms_pkg::t_cmd_in    i_cmd,
    output sms_pkg::t_job       o_job,
    output sms_pkg::t_limits    o_lim
);
    logic [6:0]  r_rows;
    logic [6:0]  r_cols;
    logic [30:0] r_tol;
    logic [6:0]  eff_rows;
    logic [6:0]  eff_cols;
    logic        out_rc;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_rows <= 7'd64;
            r_cols <= 7'd64;
            r_tol  <= '0;
        end else if (i_cfg_we) begin
            unique case (i_cfg_idx)
                sms_pkg::CFG_ROWS: r_rows <= i_cfg_data[6:0];
                sms_pkg::CFG_COLS: r_cols <= i_cfg_data[6:0];
                sms_pkg::CFG_TOL:  r_tol  <= i_cfg_data;
                default: ;
            endcase
        end
    end

    assign eff_rows = (r_rows > 7'(sms_pkg::MAX_ROWS)) ? 7'(sms_pkg::MAX_ROWS) : r_rows;
    assign eff_cols = (r_cols > 7'(sms_pkg::MAX_COLS)) ? 7'(sms_pkg::MAX_COLS) : r_cols;
    assign out_rc   = ({1'b0, i_cmd.row_index} >= eff_rows)
                   || ({1'b0, i_cmd.col_index} >= eff_cols);

    assign o_lim = '{rows: eff_rows, cols: eff_cols, tol: r_tol};

    always_comb begin
        o_job.kind   = sms_pkg::J_REPLY;
        o_job.status = sms_pkg::ST_RANGE;
        o_job.row    = i_cmd.row_index;
        o_job.col    = i_cmd.col_index;
        o_job.value  = i_cmd.value_in;
        unique case (i_cmd.command)
            sms_pkg::CMD_INSERT: begin
                if (out_rc) begin
                    o_job.kind = sms_pkg::J_REPLY;
                end else if (sms_pkg::f_small({i_cmd.value_in[31], i_cmd.value_in}, r_tol)) begin
                    o_job.status = sms_pkg::ST_OK;   // drop a negligible value
                end else begin
                    o_job.kind   = sms_pkg::J_INSERT;
                    o_job.status = sms_pkg::ST_OK;
                end
            end
            sms_pkg::CMD_VEC_WR: begin
                if ({1'b0, i_cmd.col_index} < eff_cols) begin
                    o_job.kind   = sms_pkg::J_VEC;
                    o_job.status = sms_pkg::ST_OK;
                end
            end
            sms_pkg::CMD_LOOKUP: begin
                if (!out_rc) begin
                    o_job.kind   = sms_pkg::J_LOOKUP;
                    o_job.status = sms_pkg::ST_OK;
                end
            end
            sms_pkg::CMD_MUL: begin
                if (eff_rows != 7'd0) begin
                    o_job.kind   = sms_pkg::J_MUL;
                    o_job.status = sms_pkg::ST_OK;
                end
            end
            sms_pkg::CMD_CLEAR: begin
                o_job.kind   = sms_pkg::J_CLEAR;
                o_job.status = sms_pkg::ST_OK;
            end
            default: ;
        endcase
    end
endmodule

// ----- rtl/sms_queue.sv -----
// Two-deep job queue between front and back.
`timescale 1ns / 1ps
module sms_queue (
    input  logic           i_clk,
    input  logic           i_rst_n,
    input  logic           i_push,
    input  sms_pkg::t_job  i_data,
    output logic           o_full,
    input  logic           i_pop,
    output logic           o_empty,
    output sms_pkg::t_job  o_data
);
    sms_pkg::t_job r_mem [2];
    logic       r_wp;
    logic       r_rp;
    logic [1:0] r_cnt;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wp  <= 1'b0;
            r_rp  <= 1'b0;
            r_cnt <= '0;
        end else begin
            if (i_push) r_wp <= ~r_wp;
            if (i_pop)  r_rp <= ~r_rp;
            r_cnt <= r_cnt + 2'(i_push) - 2'(i_pop);
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_push) r_mem[r_wp] <= i_data;
    end

    assign o_full  = (r_cnt == 2'd2);
    assign o_empty = (r_cnt == 2'd0);
    assign o_data  = r_mem[r_rp];
endmodule

// ----- rtl/sms_back.sv -----
// Back end: entry store scans, vector store and the multiply datapath.
`timescale 1ns / 1ps
module sms_back #(
    parameter int MAX_ENTRIES = 256
) (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              i_empty,
    input  sms_pkg::t_job     i_job,
    output logic              o_pop,
    input  sms_pkg::t_limits  i_lim,
    output logic              o_strobe,
    output sms_pkg::t_result  o_result
);
    localparam int AW   = $clog2(MAX_ENTRIES);
    localparam int CW   = $clog2(MAX_ENTRIES + 1);
    localparam int ACCW = 64 + $clog2(MAX_ENTRIES);
    localparam int VA   = sms_pkg::VEC_AW;

    sms_pkg::t_state   r_state, n_state;
    sms_pkg::t_job     r_job, n_job;
    logic [CW-1:0]     r_count, n_count;
    logic [CW-1:0]     r_idx, n_idx;
    logic              r_pv, n_pv;
    logic [AW-1:0]     r_pidx, n_pidx;
    logic [AW-1:0]     r_hidx, n_hidx;
    logic              r_p2v, n_p2v;
    logic signed [31:0] r_p2val, n_p2val;
    logic [VA-1:0]     r_p2col, n_p2col;
    logic              r_p3v, n_p3v;
    logic signed [63:0] r_prod, n_prod;
    logic signed [ACCW-1:0] r_acc, n_acc;
    logic [6:0]        r_row, n_row;
    logic [1:0]        r_ostat, n_ostat;
    logic signed [31:0] r_oval, n_oval;
    logic [sms_pkg::VEC_DEPTH-1:0] r_vvalid, n_vvalid;
    logic              r_ostb, n_ostb;
    sms_pkg::t_result  r_ores, n_ores;

    logic              e_we;
    logic [AW-1:0]     e_waddr, e_raddr;
    sms_pkg::t_entry   e_wdata, e_rdata;
    logic              v_we;
    logic [VA-1:0]     v_waddr, v_raddr;
    logic [31:0]       v_rdata;

    logic signed [32:0] sum33;
    logic signed [31:0] sum_sat;
    logic signed [31:0] vec_op;
    logic signed [ACCW-1:0] acc_sh;
    logic signed [31:0] row_sat;
    logic              acc_hi_ok;
    logic              hit;
    logic              scan_done;

    sms_ram #(.WIDTH($bits(sms_pkg::t_entry)), .DEPTH(MAX_ENTRIES)) u_entries (
        .i_clk(i_clk), .i_we(e_we), .i_waddr(e_waddr), .i_wdata(e_wdata),
        .i_raddr(e_raddr), .o_rdata(e_rdata)
    );

    sms_ram #(.WIDTH(32), .DEPTH(sms_pkg::VEC_DEPTH)) u_vector (
        .i_clk(i_clk), .i_we(v_we), .i_waddr(v_waddr), .i_wdata(r_job.value),
        .i_raddr(v_raddr), .o_rdata(v_rdata)
    );

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state  <= sms_pkg::S_IDLE;
            r_count  <= '0;
            r_pv     <= 1'b0;
            r_p2v    <= 1'b0;
            r_p3v    <= 1'b0;
            r_vvalid <= '0;
            r_ostb   <= 1'b0;
        end else begin
            r_state  <= n_state;
            r_count  <= n_count;
            r_pv     <= n_pv;
            r_p2v    <= n_p2v;
            r_p3v    <= n_p3v;
            r_vvalid <= n_vvalid;
            r_ostb   <= n_ostb;
        end
    end

    always_ff @(posedge i_clk) begin
        r_job   <= n_job;
        r_idx   <= n_idx;
        r_pidx  <= n_pidx;
        r_hidx  <= n_hidx;
        r_p2val <= n_p2val;
        r_p2col <= n_p2col;
        r_prod  <= n_prod;
        r_acc   <= n_acc;
        r_row   <= n_row;
        r_ostat <= n_ostat;
        r_oval  <= n_oval;
        r_ores  <= n_ores;
    end

    // Accumulate onto the held entry, saturating to the value width.
    assign sum33   = {e_rdata.val[31], e_rdata.val} + {r_job.value[31], r_job.value};
    assign sum_sat = (sum33[32] != sum33[31]) ? (sum33[32] ? 32'sh8000_0000 : 32'sh7FFF_FFFF)
                                               : sum33[31:0];
    assign vec_op  = r_vvalid[r_p2col] ? $signed(v_rdata) : 32'sd0;

    // Floor the Q32.32 row sum to Q16.16, then saturate.
    assign acc_sh    = r_acc >>> 16;
    assign acc_hi_ok = (acc_sh[ACCW-1:31] == '0) || (acc_sh[ACCW-1:31] == '1);
    assign row_sat   = acc_hi_ok ? acc_sh[31:0]
                     : (acc_sh[ACCW-1] ? 32'sh8000_0000 : 32'sh7FFF_FFFF);

    assign hit       = r_pv && (e_rdata.row == r_job.row) && (e_rdata.col == r_job.col);
    assign scan_done = !r_pv && (r_idx >= r_count);

    always_comb begin
        n_state  = r_state;
        n_job    = r_job;
        n_count  = r_count;
        n_idx    = r_idx;
        n_pv     = 1'b0;
        n_pidx   = r_idx[AW-1:0];
        n_hidx   = r_hidx;
        n_p2v    = 1'b0;
        n_p2val  = e_rdata.val;
        n_p2col  = e_rdata.col;
        n_p3v    = r_p2v;
        n_prod   = r_p2val * vec_op;
        n_acc    = r_acc;
        n_row    = r_row;
        n_ostat  = r_ostat;
        n_oval   = r_oval;
        n_vvalid = r_vvalid;
        n_ostb   = 1'b0;
        n_ores   = r_ores;
        o_pop    = 1'b0;
        e_we     = 1'b0;
        e_waddr  = r_pidx;
        e_wdata  = '{row: r_job.row, col: r_job.col, val: sum_sat};
        e_raddr  = r_idx[AW-1:0];
        v_we     = 1'b0;
        v_waddr  = r_job.col;
        v_raddr  = e_rdata.col;

        unique case (r_state)
            sms_pkg::S_IDLE: begin
                if (!i_empty) begin
                    o_pop   = 1'b1;
                    n_job   = i_job;
                    n_ostat = i_job.status;
                    n_oval  = '0;
                    n_idx   = '0;
                    n_row   = '0;
                    n_acc   = '0;
                    unique case (i_job.kind)
                        sms_pkg::J_REPLY:  n_state = sms_pkg::S_EMIT;
                        sms_pkg::J_VEC:    n_state = sms_pkg::S_EMIT;
                        sms_pkg::J_CLEAR: begin
                            n_count = '0;
                            n_state = sms_pkg::S_EMIT;
                        end
                        sms_pkg::J_MUL:    n_state = sms_pkg::S_MSCAN;
                        default:           n_state = sms_pkg::S_SCAN;
                    endcase
                end
            end
            sms_pkg::S_SCAN: begin
                if (r_idx < r_count) begin
                    n_pv  = 1'b1;
                    n_idx = r_idx + CW'(1);
                end
                priority if (hit) begin
                    n_state = sms_pkg::S_EMIT;
                    if (r_job.kind == sms_pkg::J_LOOKUP) begin
                        n_oval = e_rdata.val;
                    end else if (sms_pkg::f_small({sum_sat[31], sum_sat}, i_lim.tol)) begin
                        // Remove: fill the hole with the last entry.
                        if (CW'(r_pidx) == r_count - CW'(1)) begin
                            n_count = r_count - CW'(1);
                        end else begin
                            n_hidx  = r_pidx;
                            n_state = sms_pkg::S_DEL_RD;
                        end
                    end else begin
                        e_we = 1'b1;
                    end
                end else if (scan_done) begin
                    n_state = sms_pkg::S_EMIT;
                    if (r_job.kind == sms_pkg::J_INSERT) begin
                        if (r_count >= CW'(MAX_ENTRIES)) begin
                            n_ostat = sms_pkg::ST_FULL;
                        end else begin
                            e_we    = 1'b1;
                            e_waddr = r_count[AW-1:0];
                            e_wdata = '{row: r_job.row, col: r_job.col, val: r_job.value};
                            n_count = r_count + CW'(1);
                        end
                    end
                end else begin
                end
            end
            sms_pkg::S_DEL_RD: begin
                e_raddr = AW'(r_count - CW'(1));
                n_state = sms_pkg::S_DEL_WR;
            end
            sms_pkg::S_DEL_WR: begin
                e_we    = 1'b1;
                e_waddr = r_hidx;
                e_wdata = e_rdata;
                n_count = r_count - CW'(1);
                n_state = sms_pkg::S_EMIT;
            end
            sms_pkg::S_EMIT: begin
                if (r_job.kind == sms_pkg::J_VEC) begin
                    v_we = 1'b1;
                    n_vvalid[r_job.col] = 1'b1;
                end
                n_ostb  = 1'b1;
                n_ores  = '{status: r_ostat, value_out: r_oval, result_row: '0,
                            entry_count: 9'(r_count), last: 1'b1};
                n_state = sms_pkg::S_IDLE;
            end
            sms_pkg::S_MSCAN: begin
                // Stage 0: read entry; 1: read vector; 2: multiply; 3: accumulate.
                if (r_idx < r_count) begin
                    n_pv  = 1'b1;
                    n_idx = r_idx + CW'(1);
                end
                if (r_pv && ({1'b0, e_rdata.row} == r_row) && ({1'b0, e_rdata.col} < i_lim.cols)) begin
                    n_p2v = 1'b1;
                end
                if (r_p3v) begin
                    n_acc = r_acc + ACCW'(r_prod);
                end
                if (scan_done && !r_p2v && !r_p3v) begin
                    n_state = sms_pkg::S_MEMIT;
                end
            end
            sms_pkg::S_MEMIT: begin
                n_ostb = 1'b1;
                n_ores = '{status: sms_pkg::ST_OK, value_out: row_sat, result_row: r_row[5:0],
                           entry_count: 9'(r_count), last: (r_row + 7'd1 == i_lim.rows)};
                n_row  = r_row + 7'd1;
                n_acc  = '0;
                n_idx  = '0;
                n_state = (r_row + 7'd1 == i_lim.rows) ? sms_pkg::S_IDLE : sms_pkg::S_MSCAN;
            end
            default: n_state = sms_pkg::S_IDLE;
        endcase
    end

    assign o_strobe = r_ostb;
    assign o_result = r_ores;
endmodule

// ----- rtl/sparse_matrix_store_and_spmv.sv -----
// Top level of the sparse matrix store with matrix-vector multiply.
//
//  channel   | direction | handshake                | payload
//  ----------+-----------+--------------------------+-----------------------
//  command   | in        | i_start, o_busy          | i_cmd    (t_cmd_in)
//  result    | out       | o_strobe (one cycle)     | o_result (t_result)
//  config    | in        | i_cfg_we                 | i_cfg_idx, i_cfg_data
//
// A command beat is taken when i_start is high and o_busy low; o_busy rises
// only while the two-deep job queue is full.
// Reply-only commands, vector writes and clear go straight to the reply; insert
// and lookup scan the entry store, one entry a cycle. Multiply scans the
// store once per row, through the single read port of the entry memory.
// Reset is synchronous: it empties the store, zeroes the vector and restores
// the registers. No clearing pass follows. Result beats cannot be stalled.
`timescale 1ns / 1ps
module sparse_matrix_store_and_spmv #(
    parameter int MAX_ENTRIES = 256
) (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  logic               i_start,
    output logic               o_busy,
    input  sms_pkg::t_cmd_in   i_cmd,
    output logic               o_strobe,
    output sms_pkg::t_result   o_result,
    input  logic               i_cfg_we,
    input  logic [1:0]         i_cfg_idx,
    input  logic [30:0]        i_cfg_data
);
    sms_pkg::t_job    fr_job;
    sms_pkg::t_job    q_job;
    sms_pkg::t_limits lim;
    logic             q_full;
    logic             q_empty;
    logic             q_pop;
    logic             push;

    // Accept a command beat whenever the queue has room.
    assign push   = i_start && !q_full;
    assign o_busy = q_full;

    sms_front u_front (
        .i_clk(i_clk), .i_rst_n(i_rst_n),
        .i_cfg_we(i_cfg_we), .i_cfg_idx(i_cfg_idx), .i_cfg_data(i_cfg_data),
        .i_cmd(i_cmd), .o_job(fr_job), .o_lim(lim)
    );

    sms_queue u_queue (
        .i_clk(i_clk), .i_rst_n(i_rst_n),
        .i_push(push), .i_data(fr_job), .o_full(q_full),
        .i_pop(q_pop), .o_empty(q_empty), .o_data(q_job)
    );

    sms_back #(.MAX_ENTRIES(MAX_ENTRIES)) u_back (
        .i_clk(i_clk), .i_rst_n(i_rst_n),
        .i_empty(q_empty), .i_job(q_job), .o_pop(q_pop), .i_lim(lim),
        .o_strobe(o_strobe), .o_result(o_result)
    );
endmodule

// ----- rtl/sms_checker.sv -----
// Port-level checks on the result channel, bound to the top level.
`timescale 1ns / 1ps
module sms_checker #(
    parameter int MAX_ENTRIES = 256
) (
    input logic              i_clk,
    input logic              i_rst_n,
    input logic              o_strobe,
    input sms_pkg::t_result  o_result
);
    // No result beat in the cycle after reset.
    a_reset_quiet: assert property (@(posedge i_clk) !i_rst_n |=> !o_strobe)
        else $error("result beat straight after reset");

    a_err_zero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_strobe && o_result.status != sms_pkg::ST_OK) |-> (o_result.value_out == 32'sd0))
        else $error("error beat carries a value");

    a_err_last: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_strobe && o_result.status != sms_pkg::ST_OK) |-> o_result.last)
        else $error("error beat is not the last of its command");

    a_count_max: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_strobe |-> (32'(o_result.entry_count) <= MAX_ENTRIES))
        else $error("entry count above store size");
endmodule

bind sparse_matrix_store_and_spmv sms_checker #(.MAX_ENTRIES(MAX_ENTRIES)) u_chk (.*);

// ----- tb/sv/sparse_matrix_store_and_spmv_tb.sv -----
// Self-checking testbench of the sparse matrix store with matrix-vector multiply.
`timescale 1ns / 1ps
module sparse_matrix_store_and_spmv_tb;
    import sms_pkg::*;

    // Command codes the block does not know; each must come back as a range error.
    localparam logic [2:0] CMD_SPARE_A = 3'd5;
    localparam logic [2:0] CMD_SPARE_B = 3'd6;
    localparam logic [2:0] CMD_SPARE_C = 3'd7;

    localparam int STORE_DEPTH = 256;

    // Kinds of random traffic.
    localparam int MIX_GENERAL = 0;
    localparam int MIX_FILL    = 1;

    logic     i_clk = 1'b0;
    logic     i_rst_n = 1'b0;
    logic     i_start = 1'b0;
    logic     o_busy;
    t_cmd_in  i_cmd = '0;
    logic     o_strobe;
    t_result  o_result;
    logic     i_cfg_we = 1'b0;
    logic [1:0]  i_cfg_idx = '0;
    logic [30:0] i_cfg_data = '0;

    sparse_matrix_store_and_spmv dut (.*);

    always #5 i_clk = ~i_clk;

    // Hard stop: a run that hangs is a broken run.
    initial begin
        #1s;
        $display("[FAIL] regression broken");
        $finish;
    end

    // ------------------------------------------------------------------
    // Predictor state: a sorted copy of the entry store, the vector and the
    // three registers, all kept in step with the commands the block accepts.
    // ------------------------------------------------------------------
    t_entry   matrix_entries[$];
    longint   vector_elems[64];
    logic [6:0]  rows_reg;
    logic [6:0]  cols_reg;
    logic [30:0] tol_reg;

    // Results still owed by the block, oldest first.
    t_result  owed_results[$];
    int       fail_count = 0;
    int       idle_pct = 0;

    function automatic int eff_rows();
        return (rows_reg > 64) ? 64 : int'(rows_reg);
    endfunction

    function automatic int eff_cols();
        return (cols_reg > 64) ? 64 : int'(cols_reg);
    endfunction

    function automatic bit below_tol(longint v);
        longint t;
        t = longint'(tol_reg);
        return (v <= t) && (v >= -t);
    endfunction

    function automatic longint clamp32(longint v);
        if (v > 64'sd2147483647) return 64'sd2147483647;
        if (v < -64'sd2147483648) return -64'sd2147483648;
        return v;
    endfunction

    function automatic t_result reply(logic [1:0] st, longint v, int row, bit fin);
        t_result r;
        r.status      = st;
        r.value_out   = v[31:0];
        r.result_row  = row[5:0];
        r.entry_count = 9'(matrix_entries.size());
        r.last        = fin;
        return r;
    endfunction

    // Append one result to the tail of the debt list.
    function automatic void owe_result(t_result r);
        owed_results = {owed_results, r};
    endfunction

    // Apply one accepted command to the predictor and queue what it owes.
    task automatic apply_command(input t_cmd_in c);
        int rr, cc, r, col, p;
        longint v, s, vsum;
        logic signed [127:0] acc, shifted;
        t_entry e;
        rr  = eff_rows();
        cc  = eff_cols();
        r   = int'(c.row_index);
        col = int'(c.col_index);
        v   = longint'(c.value_in);
        case (c.command)
            CMD_INSERT: begin
                if (r >= rr || col >= cc) begin
                    owe_result(reply(ST_RANGE, 0, 0, 1));
                end else if (below_tol(v)) begin
                    owe_result(reply(ST_OK, 0, 0, 1));
                end else begin
                    p = 0;
                    while (p < matrix_entries.size() && (matrix_entries[p].row < r ||
                           (matrix_entries[p].row == r && matrix_entries[p].col < col)))
                        p++;
                    if (p < matrix_entries.size() && matrix_entries[p].row == r &&
                        matrix_entries[p].col == col) begin
                        // Held position: accumulate, drop the entry if it cancels out.
                        s = clamp32(longint'(matrix_entries[p].val) + v);
                        if (below_tol(s)) matrix_entries.delete(p);
                        else matrix_entries[p].val = s[31:0];
                        owe_result(reply(ST_OK, 0, 0, 1));
                    end else if (matrix_entries.size() >= STORE_DEPTH) begin
                        owe_result(reply(ST_FULL, 0, 0, 1));
                    end else begin
                        e.row = 6'(r);
                        e.col = 6'(col);
                        e.val = c.value_in;
                        matrix_entries.insert(p, e);
                        owe_result(reply(ST_OK, 0, 0, 1));
                    end
                end
            end
            CMD_VEC_WR: begin
                if (col >= cc) begin
                    owe_result(reply(ST_RANGE, 0, 0, 1));
                end else begin
                    vector_elems[col] = v;
                    owe_result(reply(ST_OK, 0, 0, 1));
                end
            end
            CMD_LOOKUP: begin
                if (r >= rr || col >= cc) begin
                    owe_result(reply(ST_RANGE, 0, 0, 1));
                end else begin
                    s = 0;
                    foreach (matrix_entries[k])
                        if (matrix_entries[k].row == r && matrix_entries[k].col == col)
                            s = matrix_entries[k].val;
                    owe_result(reply(ST_OK, s, 0, 1));
                end
            end
            CMD_MUL: begin
                if (rr == 0) begin
                    owe_result(reply(ST_RANGE, 0, 0, 1));
                end else begin
                    for (int row = 0; row < rr; row++) begin
                        // Sum exact Q32.32 products, floor to Q16.16, then saturate.
                        acc = '0;
                        foreach (matrix_entries[k])
                            if (matrix_entries[k].row == row && matrix_entries[k].col < cc)
                                acc += 128'(longint'(matrix_entries[k].val) *
                                            vector_elems[matrix_entries[k].col]);
                        shifted = acc >>> 16;
                        if (shifted > 128'sd2147483647) vsum = 64'sd2147483647;
                        else if (shifted < -128'sd2147483648) vsum = -64'sd2147483648;
                        else vsum = longint'(shifted);
                        owe_result(reply(ST_OK, vsum, row, row == rr - 1));
                    end
                end
            end
            CMD_CLEAR: begin
                matrix_entries.delete();
                owe_result(reply(ST_OK, 0, 0, 1));
            end
            default: owe_result(reply(ST_RANGE, 0, 0, 1));
        endcase
    endtask

    // ------------------------------------------------------------------
    // Result checker: every strobed beat is matched against the oldest debt.
    // ------------------------------------------------------------------
    always @(posedge i_clk) begin
        t_result want;
        if (i_rst_n && o_strobe) begin
            if (owed_results.size() == 0) begin
                $error("result beat with nothing owed: %p", o_result);
                fail_count++;
            end else begin
                want = owed_results.pop_front();
                if (o_result.status !== want.status) begin
                    $error("status: expected %0d, got %0d", want.status, o_result.status);
                    fail_count++;
                end
                if (o_result.value_out !== want.value_out) begin
                    $error("value_out: expected %0d, got %0d", want.value_out,
                           o_result.value_out);
                    fail_count++;
                end
                if (o_result.result_row !== want.result_row) begin
                    $error("result_row: expected %0d, got %0d", want.result_row,
                           o_result.result_row);
                    fail_count++;
                end
                if (o_result.entry_count !== want.entry_count) begin
                    $error("entry_count: expected %0d, got %0d", want.entry_count,
                           o_result.entry_count);
                    fail_count++;
                end
                if (o_result.last !== want.last) begin
                    $error("last: expected %0d, got %0d", want.last, o_result.last);
                    fail_count++;
                end
            end
        end
    end

    // ------------------------------------------------------------------
    // Command driver. Idle gaps go in front of the beat; start stays high
    // across back-to-back beats. Prediction happens at the accepting edge.
    // ------------------------------------------------------------------
    task automatic issue_beat(input t_cmd_in c, input bit typed, input t_result typed_res);
        while ($urandom_range(0, 99) < idle_pct) begin
            i_start <= 1'b0;
            @(posedge i_clk);
        end
        i_start <= 1'b1;
        i_cmd   <= c;
        do @(posedge i_clk); while (o_busy);
        apply_command(c);
        // Where the answer is obvious, hold the block to the typed-in value.
        if (typed) owed_results[$] = typed_res;
    endtask

    // Drain the block, let it settle, then write one register.
    task automatic write_reg(input logic [1:0] idx, input logic [30:0] data);
        while (owed_results.size() != 0) @(posedge i_clk);
        repeat (8) @(posedge i_clk);
        i_cfg_we   <= 1'b1;
        i_cfg_idx  <= idx;
        i_cfg_data <= data;
        @(posedge i_clk);
        i_cfg_we   <= 1'b0;
        case (idx)
            CFG_ROWS: rows_reg = data[6:0];
            CFG_COLS: cols_reg = data[6:0];
            default:  tol_reg  = data;
        endcase
    endtask

    // Value picker: mostly wide random, some hugging the tolerance edge.
    function automatic logic [31:0] pick_value();
        longint m;
        if ($urandom_range(0, 3) != 0) return $urandom;
        m = longint'(tol_reg) + $urandom_range(0, 2) - 1;
        return ($urandom_range(0, 1) != 0) ? m[31:0] : -m[31:0];
    endfunction

    function automatic t_cmd_in draw_command(input int mix);
        t_cmd_in c;
        int pick, rr, cc, k;
        rr = eff_rows();
        cc = eff_cols();
        c.command   = CMD_INSERT;
        c.row_index = 6'($urandom);
        c.col_index = 6'($urandom);
        c.value_in  = pick_value();
        pick = $urandom_range(0, 99);
        // Keep most indices inside the window so the deep paths get exercised.
        if (rr > 0 && pick % 8 != 0) c.row_index = 6'($urandom_range(0, rr - 1));
        if (cc > 0 && pick % 8 != 1) c.col_index = 6'($urandom_range(0, cc - 1));
        if (mix == MIX_FILL) begin
            c.value_in = $urandom | 32'h0010_0000;
            if (pick < 1) c.command = CMD_MUL;
            else if (pick < 3) c.command = CMD_LOOKUP;
        end else if (pick < 35) begin
            c.command = CMD_INSERT;
        end else if (pick < 47) begin
            // Accumulate onto a held entry, often cancelling it.
            if (matrix_entries.size() != 0) begin
                k = $urandom_range(0, matrix_entries.size() - 1);
                c.row_index = matrix_entries[k].row;
                c.col_index = matrix_entries[k].col;
                c.value_in  = ($urandom_range(0, 1) != 0) ? -matrix_entries[k].val :
                              pick_value();
            end
        end else if (pick < 62) begin
            c.command = CMD_VEC_WR;
        end else if (pick < 77) begin
            c.command = CMD_LOOKUP;
            if (matrix_entries.size() != 0 && pick < 72) begin
                k = $urandom_range(0, matrix_entries.size() - 1);
                c.row_index = matrix_entries[k].row;
                c.col_index = matrix_entries[k].col;
            end
        end else if (pick < 88) begin
            c.command = CMD_MUL;
        end else if (pick < 91) begin
            c.command = CMD_CLEAR;
        end else if (pick < 94) begin
            c.command = ($urandom_range(0, 2) == 0) ? CMD_SPARE_A :
                        ($urandom_range(0, 1) != 0) ? CMD_SPARE_B : CMD_SPARE_C;
        end else begin
            c.row_index = 6'($urandom);
            c.col_index = 6'($urandom);
        end
        return c;
    endfunction

    // Directed beats: command, row, col, value, typed flag, typed result.
    typedef struct {
        logic [2:0]  cmd;
        logic [5:0]  row;
        logic [5:0]  col;
        logic [31:0] val;
        bit          typed;
        t_result     res;
    } t_directed;

    typedef struct {
        logic [30:0] rows;
        logic [30:0] cols;
        logic [30:0] tol;
        int          beats;
        int          idle;
        int          mix;
    } t_phase;

    t_directed directed_beats[$];
    t_phase    phases[$];

    initial begin
        t_result nil;
        nil = '0;
        nil.last = 1'b1;
        foreach (vector_elems[i]) vector_elems[i] = 0;
        rows_reg = 7'd64;
        cols_reg = 7'd64;
        tol_reg  = '0;

        directed_beats = '{
            '{CMD_LOOKUP,  6'd0,  6'd0,  32'h0,        1, nil},
            '{CMD_SPARE_A, 6'd1,  6'd1,  32'h0,        1, '{ST_RANGE, 0, 0, 0, 1}},
            '{CMD_SPARE_B, 6'd63, 6'd63, 32'hFFFF_FFFF, 1, '{ST_RANGE, 0, 0, 0, 1}},
            '{CMD_SPARE_C, 6'd0,  6'd0,  32'h0,        1, '{ST_RANGE, 0, 0, 0, 1}},
            '{CMD_MUL,     6'd0,  6'd0,  32'h0,        0, nil},
            '{CMD_INSERT,  6'd0,  6'd0,  32'h0,        1, nil},
            '{CMD_INSERT,  6'd63, 6'd63, 32'h7FFF_FFFF, 0, nil},
            '{CMD_INSERT,  6'd0,  6'd0,  32'h8000_0000, 0, nil},
            '{CMD_INSERT,  6'd0,  6'd0,  32'hFFFF_FFFF, 0, nil},
            '{CMD_LOOKUP,  6'd0,  6'd0,  32'h0,        0, nil},
            '{CMD_INSERT,  6'd63, 6'd63, 32'h7FFF_FFFF, 0, nil},
            '{CMD_INSERT,  6'd5,  6'd9,  32'h0001_0000, 0, nil},
            '{CMD_INSERT,  6'd5,  6'd9,  32'hFFFF_0000, 0, nil},
            '{CMD_LOOKUP,  6'd5,  6'd9,  32'h0,        0, nil},
            '{CMD_INSERT,  6'd5,  6'd2,  32'h0003_8000, 0, nil},
            '{CMD_VEC_WR,  6'd0,  6'd63, 32'h7FFF_FFFF, 0, nil},
            '{CMD_VEC_WR,  6'd0,  6'd0,  32'h8000_0000, 0, nil},
            '{CMD_VEC_WR,  6'd0,  6'd2,  32'hFFFE_8000, 0, nil},
            '{CMD_MUL,     6'd0,  6'd0,  32'h0,        0, nil},
            '{CMD_LOOKUP,  6'd63, 6'd63, 32'h0,        0, nil},
            '{CMD_CLEAR,   6'd0,  6'd0,  32'h0,        0, nil},
            '{CMD_MUL,     6'd0,  6'd0,  32'h0,        0, nil}
        };

        // Register settings walk from defaults through the extremes; the fill
        // phase drives the store into its full state.
        phases = '{
            '{31'd64,  31'd64,  31'd0,          30,  0, MIX_GENERAL},
            '{31'd8,   31'd8,   31'h100,        50, 79, MIX_GENERAL},
            '{31'd1,   31'd1,   31'd0,          20,  0, MIX_GENERAL},
            '{31'd127, 31'd127, 31'h7FFF_FFFF,  15, 18, MIX_GENERAL},
            '{31'd0,   31'd0,   31'd0,          12,  0, MIX_GENERAL},
            '{31'd64,  31'd64,  31'd0,         290,  0, MIX_FILL},
            '{31'd16,  31'd40,  31'h10000,      35, 79, MIX_GENERAL}
        };

        repeat (12) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        foreach (directed_beats[i]) begin
            t_cmd_in c;
            c.command   = directed_beats[i].cmd;
            c.row_index = directed_beats[i].row;
            c.col_index = directed_beats[i].col;
            c.value_in  = directed_beats[i].val;
            issue_beat(c, directed_beats[i].typed, directed_beats[i].res);
        end
        i_start <= 1'b0;

        foreach (phases[p]) begin
            write_reg(CFG_ROWS, phases[p].rows);
            write_reg(CFG_COLS, phases[p].cols);
            write_reg(CFG_TOL,  phases[p].tol);
            idle_pct = phases[p].idle;
            repeat (phases[p].beats) issue_beat(draw_command(phases[p].mix), 0, nil);
            i_start <= 1'b0;
        end

        // Drain, then give the block time to show any stray beat.
        while (owed_results.size() != 0) @(posedge i_clk);
        repeat (200) @(posedge i_clk);
        if (fail_count == 0) begin
            $display("[ OK ] regression clean");
        end else begin
            $display("[FAIL] regression broken");
        end
        $finish;
    end

endmodule

// ----- sim.f -----
rtl/sms_pkg.sv
rtl/sms_ram.sv
rtl/sms_front.sv
rtl/sms_queue.sv
rtl/sms_back.sv
rtl/sparse_matrix_store_and_spmv.sv
rtl/sms_checker.sv
tb/sv/sparse_matrix_store_and_spmv_tb.sv
